// ===== hdl/aeq_pkg.sv =====
package aeq_pkg;

	// Default depth of the cell chain
	localparam int MAX_ENTRIES_DEF = 16;

	// Field widths
	localparam int ID_W    = 32;
	localparam int CLASS_W = 8;
	localparam int MS_W    = 16;
	localparam int AGE_W   = 17;
	localparam int COUNT_W = 5;
	localparam int CAP_W   = 5;
	localparam int REQ_W   = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE  = 8'd1;

	// Register reset values
	localparam logic [CAP_W-1:0] CAP_RESET     = 5'd16;
	localparam logic [MS_W-1:0]  MAX_AGE_RESET = 16'd5000;

	// One queue entry as held in a cell
	typedef struct packed {
		logic [ID_W-1:0]    killer;
		logic [ID_W-1:0]    victim;
		logic [CLASS_W-1:0] weapon;
		logic [AGE_W-1:0]   age;
	} entry_t;

	// Operation broadcast to every cell
	typedef struct packed {
		logic push;
		logic tick;
		logic clear;
		logic grow;   // push adds an entry instead of dropping the oldest
	} cell_ctl_t;

endpackage

// ===== hdl/aeq_cell.sv =====
module aeq_cell import aeq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  cell_ctl_t       ctl,
	input  logic [MS_W-1:0] elapsed_ms,
	input  logic [MS_W-1:0] max_age_ms,
	input  logic            prev_live,
	input  entry_t          prev_entry,
	output logic            live,
	output entry_t          entry
);

	logic             live_q;
	entry_t           entry_q;
	logic [AGE_W-1:0] age_sum;
	logic             keep;

	// Aged value and survival test for a tick
	always_comb begin
		age_sum = entry_q.age + {1'b0, elapsed_ms};
		keep    = live_q && (age_sum <= {1'b0, max_age_ms});
	end

	// Live flag: the chain of these forms the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (ctl.clear) begin
			live_q <= 1'b0;
		end else if (ctl.push && ctl.grow) begin
			live_q <= prev_live;
		end else if (ctl.tick) begin
			live_q <= keep;
		end
	end

	// Entry data: shift back on push, age in place on tick
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= prev_entry;
		end else if (ctl.tick) begin
			entry_q.age <= age_sum;
		end
	end

	assign live  = live_q;
	assign entry = entry_q;

endmodule

// ===== hdl/aging_event_queue.sv =====
// Aging event queue: newest-first list of events with age expiry.
// Command channel: an item is taken at a rising edge with start high and
// busy low; busy stays low, so one item can be taken every cycle.
// req_type selects push (store killer_id, victim_id, event_class as the
// newest entry with age zero), tick (add elapsed_ms to every age and drop
// entries older than max_age_ms), clear, or query only.
// Each item gives one result word: done is high for exactly one cycle, the
// cycle right after the accepting edge, with the newest entry and the count
// after that item. The receiver cannot stall; the word is gone after that
// cycle.
// Throughput is one item per cycle: a row of MAX_ENTRIES cells shifts and
// ages all entries at once at the accepting edge, and the result ports show
// cell 0 and the fill level of the row, which hold the state after the item
// during the done cycle.
// Configuration: cfg_valid/cfg_ready (always ready), cfg_index 0 sets the
// capacity in use, 1 sets the maximum age; other indexes are ignored.
// Reset empties the queue and loads capacity 16 and maximum age 5000 ms.
module aging_event_queue import aeq_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command channel
	input  logic                  start,
	output logic                  busy,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [ID_W-1:0]       killer_id,
	input  logic [ID_W-1:0]       victim_id,
	input  logic [CLASS_W-1:0]    event_class,
	input  logic [MS_W-1:0]       elapsed_ms,
	// result
	output logic                  done,
	output logic                  newest_valid,
	output logic [ID_W-1:0]       newest_killer,
	output logic [ID_W-1:0]       newest_victim,
	output logic [CLASS_W-1:0]    newest_weapon,
	output logic [MS_W-1:0]       newest_age_ms,
	output logic [COUNT_W-1:0]    entry_count,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [8:0] MAX_W = 9'(MAX_ENTRIES);

	logic [CAP_W-1:0]       cap_q;
	logic [MS_W-1:0]        max_age_q;
	logic [8:0]             cap_lo;
	logic [8:0]             cap_eff;
	logic [8:0]             cap_m1;
	logic [IDX_W-1:0]       cap_idx;
	logic                   accept;
	cell_ctl_t              ctl;
	entry_t                 in_entry;
	entry_t                 cell_entry [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] live_vec;
	logic [MAX_ENTRIES:0]   live_ext;
	logic [CNT_W-1:0]       cnt;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;

	logic                   done_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_RESET;
			max_age_q <= MAX_AGE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CAPACITY: cap_q     <= cfg_data[CAP_W-1:0];
				REG_MAX_AGE:  max_age_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective capacity clamped to 1..MAX_ENTRIES, as the index of the last slot
	always_comb begin
		cap_lo  = (cap_q == '0) ? 9'd1 : {4'd0, cap_q};
		cap_eff = (cap_lo > MAX_W) ? MAX_W : cap_lo;
		cap_m1  = cap_eff - 9'd1;
		cap_idx = cap_m1[IDX_W-1:0];
	end

	// Command decode
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		ctl.push  = accept && (req_type == REQ_PUSH);
		ctl.tick  = accept && (req_type == REQ_TICK);
		ctl.clear = accept && (req_type == REQ_CLEAR);
		// queue is full at the capacity when the slot at cap-1 is live
		ctl.grow  = !live_vec[cap_idx];
		in_entry.killer = killer_id;
		in_entry.victim = victim_id;
		in_entry.weapon = event_class;
		in_entry.age    = '0;
	end

	// Cell chain, cell 0 holds the newest entry
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			aeq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.elapsed_ms (elapsed_ms),
				.max_age_ms (max_age_q),
				.prev_live  (1'b1),
				.prev_entry (in_entry),
				.live       (live_vec[i]),
				.entry      (cell_entry[i])
			);
		end else begin : g_body
			aeq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.elapsed_ms (elapsed_ms),
				.max_age_ms (max_age_q),
				.prev_live  (live_vec[i-1]),
				.prev_entry (cell_entry[i-1]),
				.live       (live_vec[i]),
				.entry      (cell_entry[i])
			);
		end
	end

	// Fill level: live flags form a prefix, so the count is the position of
	// its last set flag plus one
	assign live_ext = {1'b0, live_vec};

	always_comb begin
		cnt = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (live_ext[i] && !live_ext[i+1]) begin
				cnt = cnt | CNT_W'(i + 1);
			end
		end
		cnt_ext = {{COUNT_W{1'b0}}, cnt};
	end

	// Result: done marks the cycle after the accepting edge, when the row
	// already holds the state after the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	assign done          = done_q;
	assign newest_valid  = live_vec[0];
	assign newest_killer = live_vec[0] ? cell_entry[0].killer : '0;
	assign newest_victim = live_vec[0] ? cell_entry[0].victim : '0;
	assign newest_weapon = live_vec[0] ? cell_entry[0].weapon : '0;
	assign newest_age_ms = live_vec[0] ? cell_entry[0].age[MS_W-1:0] : '0;
	assign entry_count   = cnt_ext[COUNT_W-1:0];

`ifndef SYNTHESIS
	// every accepted item yields a word in the next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("result word missing after accepted item");

	// live flags always form a prefix of the chain
	a_live_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((live_vec + 1'b1) & live_vec) == '0)
		else $error("live flags are not a prefix");

	// a clear leaves an empty queue
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_CLEAR)) |=> (!newest_valid && entry_count == '0))
		else $error("clear did not empty the queue");

	// a push always leaves the new event as the newest entry
	a_push_newest: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_PUSH)) |=>
		(newest_valid && newest_killer == $past(killer_id) && newest_age_ms == '0))
		else $error("pushed event is not the newest entry");
`endif

endmodule

// ===== bench/testbench.sv =====
module testbench;
	import aeq_pkg::*;

	// One command word as driven on the command channel
	typedef struct packed {
		logic [REQ_W-1:0]   req;
		logic [ID_W-1:0]    killer;
		logic [ID_W-1:0]    victim;
		logic [CLASS_W-1:0] weapon;
		logic [MS_W-1:0]    elapsed;
	} event_req_t;

	// One result word: newest entry and fill level after a command
	typedef struct packed {
		logic               valid;
		logic [ID_W-1:0]    killer;
		logic [ID_W-1:0]    victim;
		logic [CLASS_W-1:0] weapon;
		logic [MS_W-1:0]    age;
		logic [COUNT_W-1:0] count;
	} newest_view_t;

	localparam int CYCLE_LIMIT = 200000;

	// Shadow copy of the event queue and the expected result words
	class event_queue_scoreboard;
		entry_t           cells[MAX_ENTRIES_DEF];
		int unsigned      live;
		logic [CAP_W-1:0] capacity;
		logic [MS_W-1:0]  max_age;
		newest_view_t     expected_views[$];
		int unsigned      fail_count;

		function new();
			live = 0;
			capacity = CAP_RESET;
			max_age = MAX_AGE_RESET;
			fail_count = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_CAPACITY: capacity = data[CAP_W-1:0];
				REG_MAX_AGE:  max_age = data[MS_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return expected_views.size();
		endfunction

		// Apply one accepted command and queue the word it should produce
		function void note_request(event_req_t r);
			int unsigned  cap;
			int unsigned  n;
			int unsigned  keep;
			newest_view_t want;
			case (r.req)
				REQ_PUSH: begin
					cap = capacity;
					if (cap < 1)
						cap = 1;
					if (cap > MAX_ENTRIES_DEF)
						cap = MAX_ENTRIES_DEF;
					n = live;
					// full: the oldest falls off the back
					if (n >= cap)
						n = n - 1;
					if (n > MAX_ENTRIES_DEF - 1)
						n = MAX_ENTRIES_DEF - 1;
					for (int i = n; i > 0; i--)
						cells[i] = cells[i-1];
					cells[0].killer = r.killer;
					cells[0].victim = r.victim;
					cells[0].weapon = r.weapon;
					cells[0].age = '0;
					live = n + 1;
				end
				REQ_TICK: begin
					keep = 0;
					for (int i = 0; i < live; i++) begin
						cells[i].age = cells[i].age + {1'b0, r.elapsed};
						if (cells[i].age <= {1'b0, max_age})
							keep++;
					end
					// survivors are a prefix, so only the count moves
					if (keep < live)
						live = keep;
				end
				REQ_CLEAR: live = 0;
				default: ;
			endcase
			want = '0;
			if (live > 0) begin
				want.valid = 1'b1;
				want.killer = cells[0].killer;
				want.victim = cells[0].victim;
				want.weapon = cells[0].weapon;
				want.age = cells[0].age[MS_W-1:0];
			end
			want.count = live[COUNT_W-1:0];
			expected_views.push_back(want);
		endfunction

		task report(string msg);
			if (fail_count < 40)
				$display("MISMATCH at %0t: %s", $time, msg);
			fail_count++;
		endtask

		// Compare a result word with the oldest expectation
		task check_view(newest_view_t got);
			newest_view_t want;
			if (expected_views.size() == 0) begin
				report($sformatf("unexpected result word, count %0d", got.count));
				return;
			end
			want = expected_views.pop_front();
			if (got.valid !== want.valid)
				report($sformatf("newest_valid %b, want %b", got.valid, want.valid));
			if (got.killer !== want.killer)
				report($sformatf("newest_killer %h, want %h", got.killer, want.killer));
			if (got.victim !== want.victim)
				report($sformatf("newest_victim %h, want %h", got.victim, want.victim));
			if (got.weapon !== want.weapon)
				report($sformatf("newest_weapon %h, want %h", got.weapon, want.weapon));
			if (got.age !== want.age)
				report($sformatf("newest_age_ms %0d, want %0d", got.age, want.age));
			if (got.count !== want.count)
				report($sformatf("entry_count %0d, want %0d", got.count, want.count));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [REQ_W-1:0]      req_type;
	logic [ID_W-1:0]       killer_id;
	logic [ID_W-1:0]       victim_id;
	logic [CLASS_W-1:0]    event_class;
	logic [MS_W-1:0]       elapsed_ms;
	logic                  done;
	logic                  newest_valid;
	logic [ID_W-1:0]       newest_killer;
	logic [ID_W-1:0]       newest_victim;
	logic [CLASS_W-1:0]    newest_weapon;
	logic [MS_W-1:0]       newest_age_ms;
	logic [COUNT_W-1:0]    entry_count;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	newest_view_t          seen_view;
	int                    cycle_count = 0;
	event_queue_scoreboard sb = new();

	aging_event_queue u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.killer_id     (killer_id),
		.victim_id     (victim_id),
		.event_class   (event_class),
		.elapsed_ms    (elapsed_ms),
		.done          (done),
		.newest_valid  (newest_valid),
		.newest_killer (newest_killer),
		.newest_victim (newest_victim),
		.newest_weapon (newest_weapon),
		.newest_age_ms (newest_age_ms),
		.entry_count   (entry_count),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result monitor: a word is valid for the one cycle that done is high
	assign seen_view = '{valid: newest_valid, killer: newest_killer, victim: newest_victim,
		weapon: newest_weapon, age: newest_age_ms, count: entry_count};

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_view(seen_view);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count, sb.pending());
			$display("** aging_event_queue: FAILED **");
			$finish;
		end
	end

	function automatic event_req_t make_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] k,
		logic [ID_W-1:0] v, logic [CLASS_W-1:0] w, logic [MS_W-1:0] e);
		event_req_t r;
		r.req = req;
		r.killer = k;
		r.victim = v;
		r.weapon = w;
		r.elapsed = e;
		return r;
	endfunction

	// Mostly pushes and short ticks so the queue fills and ages survive
	function automatic event_req_t random_request();
		int unsigned      sel;
		logic [REQ_W-1:0] req;
		logic [MS_W-1:0]  e;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			req = REQ_PUSH;
		else if (sel < 80)
			req = REQ_TICK;
		else if (sel < 97)
			req = REQ_QUERY;
		else
			req = REQ_CLEAR;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			e = '0;
		else if (sel == 1)
			e = '1;
		else if (sel < 6)
			e = MS_W'($urandom);
		else
			e = MS_W'($urandom_range(0, sb.max_age / 8 + 1));
		return make_request(req, $urandom, $urandom, CLASS_W'($urandom_range(0, 255)), e);
	endfunction

	function automatic int unsigned random_gap();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 0;
		if (sel < 85)
			return $urandom_range(1, 3);
		if (sel < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Present one command word and hold it until taken
	task automatic send_request(event_req_t r);
		start <= 1'b1;
		req_type <= r.req;
		killer_id <= r.killer;
		victim_id <= r.victim;
		event_class <= r.weapon;
		elapsed_ms <= r.elapsed;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(r);
	endtask

	// Idle the command channel with junk on the ignored fields
	task automatic pause_cycles(int unsigned n);
		if (n > 0) begin
			start <= 1'b0;
			req_type <= REQ_W'($urandom);
			killer_id <= $urandom;
			victim_id <= $urandom;
			event_class <= CLASS_W'($urandom);
			elapsed_ms <= MS_W'($urandom);
			repeat (n)
				@(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stimulus
	initial begin
		logic [CAP_W-1:0] phase_caps[8];
		logic [MS_W-1:0]  phase_ages[8];
		bit               quiet;

		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_QUERY;
		killer_id <= '0;
		victim_id <= '0;
		event_class <= '0;
		elapsed_ms <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_CAPACITY;
		cfg_data <= '0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queue, field extremes, age limit edges
		send_request(make_request(REQ_QUERY, '1, '1, '1, '1));
		send_request(make_request(REQ_TICK, '1, '1, '1, '1));
		send_request(make_request(REQ_CLEAR, '1, '1, '1, '1));
		send_request(make_request(REQ_PUSH, '0, '0, '0, '1));
		send_request(make_request(REQ_PUSH, '1, '1, '1, '0));
		send_request(make_request(REQ_QUERY, '0, '0, '0, '1));
		send_request(make_request(REQ_TICK, '1, '1, '1, 16'd0));
		send_request(make_request(REQ_TICK, '0, '0, '0, 16'd4999));
		// reaching the limit exactly survives, one past drops all
		send_request(make_request(REQ_TICK, '0, '0, '0, 16'd1));
		send_request(make_request(REQ_TICK, '0, '0, '0, 16'd1));
		send_request(make_request(REQ_PUSH, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'h81, '1));
		send_request(make_request(REQ_PUSH, 32'h0123_4567, 32'h89AB_CDEF, 8'h7E, '0));
		send_request(make_request(REQ_TICK, '0, '0, '0, 16'hFFFF));
		send_request(make_request(REQ_PUSH, 32'h1, 32'h2, 8'h3, '0));
		send_request(make_request(REQ_PUSH, 32'h4, 32'h5, 8'h6, '0));
		send_request(make_request(REQ_PUSH, 32'h7, 32'h8, 8'h9, '0));

		// capacity dropped below the count; unused indexes are ignored
		wait_idle();
		write_reg(REG_CAPACITY, 16'd1);
		write_reg(8'd2, 16'hFFFF);
		write_reg(8'hFF, 16'h0000);
		send_request(make_request(REQ_PUSH, 32'hDEAD_0001, 32'hBEEF_0001, 8'h11, '0));
		send_request(make_request(REQ_QUERY, '0, '0, '0, '0));
		send_request(make_request(REQ_CLEAR, '0, '0, '0, '0));

		// zero capacity acts as one; widest age window
		wait_idle();
		write_reg(REG_CAPACITY, 16'd0);
		write_reg(REG_MAX_AGE, 16'hFFFF);
		send_request(make_request(REQ_PUSH, 32'hCAFE_0001, 32'hF00D_0001, 8'h22, '0));
		send_request(make_request(REQ_PUSH, 32'hCAFE_0002, 32'hF00D_0002, 8'h33, '0));
		send_request(make_request(REQ_TICK, '0, '0, '0, 16'hFFFF));
		send_request(make_request(REQ_TICK, '0, '0, '0, 16'hFFFF));

		// Random phases over several register settings
		phase_caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd4, 5'd0, 5'd8, 5'd2};
		phase_ages = '{16'd5000, 16'd0, 16'hFFFF, 16'd100, 16'd1000, 16'd0, 16'hFFFF, 16'd20000};
		phase_caps[5] = CAP_W'($urandom_range(0, 31));
		phase_ages[5] = MS_W'($urandom);
		for (int p = 0; p < 8; p++) begin
			wait_idle();
			write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
			write_reg(REG_CAPACITY, {11'd0, phase_caps[p]});
			write_reg(REG_MAX_AGE, phase_ages[p]);
			quiet = 1'b0;
			for (int k = 0; k < 150; k++) begin
				if (k % 50 == 0)
					quiet = ($urandom_range(0, 3) == 0);
				send_request(random_request());
				if (!quiet)
					pause_cycles(random_gap());
				// now and then hold off until the queue has answered everything
				if ($urandom_range(0, 99) == 0)
					wait_idle();
			end
		end

		wait_idle();
		repeat (10)
			@(posedge clk);
		if (sb.fail_count == 0)
			$display("** aging_event_queue: PASSED **");
		else
			$display("** aging_event_queue: FAILED **");
		$finish;
	end

endmodule

// ===== aging_event_queue.f =====
hdl/aeq_pkg.sv
hdl/aeq_cell.sv
hdl/aging_event_queue.sv
bench/testbench.sv
